[rtl/pfa_pkg.sv]
package pfa_pkg;

	localparam int CFG_W  = 13;
	localparam int PID_W  = 16;
	localparam int PAGE_W = 7;
	localparam int ADDR_W = 12;
	localparam int WORD_W = 32;
	localparam int DIV_W  = 20;

	localparam logic [PAGE_W-1:0] PAGE_LIMIT = 7'd127;

	localparam logic [CFG_W-1:0] PAGE_SIZE_RESET = 13'd64;
	localparam logic [CFG_W-1:0] MEM_SIZE_RESET  = 13'd4096;

	localparam logic [2:0] REQ_START   = 3'd0;
	localparam logic [2:0] REQ_RESIZE  = 3'd1;
	localparam logic [2:0] REQ_RELEASE = 3'd2;
	localparam logic [2:0] REQ_LOOKUP  = 3'd3;
	localparam logic [2:0] REQ_READ    = 3'd4;
	localparam logic [2:0] REQ_WRITE   = 3'd5;

	localparam logic CFG_PAGE_SIZE = 1'b0;
	localparam logic CFG_MEM_SIZE  = 1'b1;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_NF_DIV,
		ST_NF_WAIT,
		ST_SCAN,
		ST_DECIDE,
		ST_MUL,
		ST_SZ_DIV,
		ST_SZ_WAIT,
		ST_SZ_DECIDE,
		ST_RW_DIV,
		ST_RW_WAIT,
		ST_RW_OWN,
		ST_RW_CHECK,
		ST_BYTES,
		ST_FINISH
	} state_t;

	typedef enum logic [1:0] {
		SCAN_GATHER,
		SCAN_DROP,
		SCAN_ALLOC
	} scan_mode_t;

	typedef struct packed {
		logic set;
		logic clr;
	} tbl_op_t;

endpackage

[rtl/pfa_div.sv]
module pfa_div #(
	parameter int DW = 20,
	parameter int VW = 13
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          start,
	input  logic [DW-1:0] dividend,
	input  logic [VW-1:0] divisor,
	output logic          done,
	output logic [DW-1:0] quot
);

	localparam int CNT_W = $clog2(DW + 1);

	logic [DW-1:0]    dd_q;
	logic [VW-1:0]    rem_q;
	logic [CNT_W-1:0] cnt_q;
	logic             done_q;
	logic [VW:0]      trial;
	logic             fits;

	// Restoring division, one quotient bit per cycle.
	assign trial = {rem_q, dd_q[DW-1]};
	assign fits  = trial >= {1'b0, divisor};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q  <= '0;
			done_q <= 1'b0;
		end else if (start) begin
			cnt_q  <= CNT_W'(DW);
			done_q <= 1'b0;
		end else if (cnt_q != '0) begin
			cnt_q  <= cnt_q - 1'b1;
			done_q <= cnt_q == CNT_W'(1);
		end else begin
			done_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			dd_q  <= dividend;
			rem_q <= '0;
		end else if (cnt_q != '0) begin
			if (fits) begin
				rem_q <= VW'(trial - {1'b0, divisor});
			end else begin
				rem_q <= trial[VW-1:0];
			end
			dd_q <= {dd_q[DW-2:0], fits};
		end
	end

	assign done = done_q;
	assign quot = dd_q;

endmodule

[rtl/pfa_tbl.sv]
module pfa_tbl #(
	parameter int MAX_FRAMES = 64,
	parameter int IW = 6,
	parameter int CW = 7
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic [IW-1:0]               raddr,
	output logic [pfa_pkg::PID_W-1:0]   rd_owner,
	output logic [pfa_pkg::PAGE_W-1:0]  rd_page,
	input  pfa_pkg::tbl_op_t            op,
	input  logic [IW-1:0]               widx,
	input  logic [pfa_pkg::PID_W-1:0]   wowner,
	input  logic [pfa_pkg::PAGE_W-1:0]  wpage,
	output logic [MAX_FRAMES-1:0]       busy,
	output logic [CW-1:0]               count
);

	localparam int EW = pfa_pkg::PID_W + pfa_pkg::PAGE_W;

	logic [EW-1:0]         entry_mem [MAX_FRAMES];
	logic [EW-1:0]         rd_q;
	logic [MAX_FRAMES-1:0] busy_q;
	logic [CW-1:0]         count_q;

	always_ff @(posedge clk) begin
		if (op.set) begin
			entry_mem[widx] <= {wowner, wpage};
		end
		rd_q <= entry_mem[raddr];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q  <= '0;
			count_q <= '0;
		end else if (op.set) begin
			busy_q[widx] <= 1'b1;
			count_q      <= count_q + 1'b1;
		end else if (op.clr) begin
			busy_q[widx] <= 1'b0;
			if (count_q != '0) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	assign rd_owner = rd_q[EW-1:pfa_pkg::PAGE_W];
	assign rd_page  = rd_q[pfa_pkg::PAGE_W-1:0];
	assign busy     = busy_q;
	assign count    = count_q;

endmodule

[rtl/paged_frame_allocator.sv]
// Paged frame allocator: hands out physical frames, numbered from 1, to processes.
// Requests arrive on the in channel (valid/ready) and each one gives exactly one
// result item on the out channel (valid/ready): status, frame number, read word.
// Registers page_size (index 0) and mem_size (index 1) are written on the cfg
// channel, which is always ready; write them only while no request is in flight.
// The block takes one request at a time. Every request of a known type first divides
// the memory size by the page size on a shared bit-serial divider. Start and lookup
// then walk the frame table once, one frame per cycle; release walks it a second
// time to free frames. A resize adds a multiply, a second division and a second
// walk. Read and write use a second division for the frame of the address, then
// touch four bytes of the byte memory.
// Reset frees all frames and loads page_size 64 and mem_size 4096; the byte
// memory is not cleared. A finished result waits in the output register while
// the receiver stalls; the next request may already be accepted and worked on,
// and its result is held back until the earlier one is taken.
module paged_frame_allocator #(
	parameter int MAX_FRAMES = 64,
	parameter int MEM_BYTES = 4096
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [2:0]  req_type,
	input  logic [15:0] pid,
	input  logic [6:0]  page_number,
	input  logic [12:0] new_size,
	input  logic [11:0] address,
	input  logic [31:0] write_value,
	output logic        out_valid,
	input  logic        out_ready,
	output logic        status,
	output logic [6:0]  frame_number,
	output logic [31:0] read_value,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic        cfg_index,
	input  logic [12:0] cfg_data
);

	localparam int IW  = MAX_FRAMES > 1 ? $clog2(MAX_FRAMES) : 1;
	localparam int CW  = $clog2(MAX_FRAMES + 1);
	localparam int BAW = $clog2(MEM_BYTES);
	localparam int DW  = pfa_pkg::DIV_W;

	pfa_pkg::state_t     state_q, state_d;
	pfa_pkg::scan_mode_t mode_q;

	logic [12:0] page_size_q, mem_size_q, ps_eff, mem_eff;

	logic [2:0]  req_q;
	logic [15:0] pid_q;
	logic [6:0]  pnum_q;
	logic [12:0] nsize_q;
	logic [11:0] addr_q;
	logic [31:0] wval_q;

	logic [CW-1:0] nf_q, free_cnt_q, alloc_left_q, cnt_q, avail, nf_gap;
	logic          own_any_q, found_q, free_found_q;
	logic [6:0]    top_page_q, thr_q, next_page_q;
	logic [IW-1:0] found_idx_q, free_idx_q, fidx_q, idx_s1;
	logic [DW-1:0] old_q, n_q;
	logic          v_s1, kv_s1;
	logic [1:0]    k_s1;
	logic [2:0]    bk_q;

	logic        res_status_q, out_valid_q, out_status_q;
	logic [6:0]  res_frame_q, out_frame_q;
	logic [31:0] res_rval_q, out_rval_q;

	logic          div_start, div_done;
	logic [DW-1:0] div_dividend, div_quot;

	logic [IW-1:0]         tbl_raddr, tbl_widx;
	logic [15:0]           tbl_owner;
	logic [6:0]            tbl_page, tbl_wpage;
	pfa_pkg::tbl_op_t      tbl_op;
	logic [MAX_FRAMES-1:0] busy_vec;
	logic [CW-1:0]         busy_cnt;

	logic s1_busy, s1_own, s1_free, scan_issue, scan_end, shrink, grow_ok;
	logic rw_ok, byte_issue, is_write;
	logic [16:0]    baddr_sum, baddr_wrap;
	logic [BAW-1:0] baddr;
	logic [7:0]     byte_mem [MEM_BYTES];
	logic [7:0]     byte_rd_q;

	assign ps_eff  = page_size_q == '0 ? 13'd1 : page_size_q;
	assign mem_eff = {4'b0, mem_size_q} > 17'(MEM_BYTES) ? 13'(MEM_BYTES) : mem_size_q;

	assign in_ready  = state_q == pfa_pkg::ST_IDLE;
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			page_size_q <= pfa_pkg::PAGE_SIZE_RESET;
			mem_size_q  <= pfa_pkg::MEM_SIZE_RESET;
		end else if (cfg_valid) begin
			if (cfg_index == pfa_pkg::CFG_PAGE_SIZE) begin
				page_size_q <= cfg_data;
			end else begin
				mem_size_q <= cfg_data;
			end
		end
	end

	pfa_div #(.DW(DW), .VW(pfa_pkg::CFG_W)) u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.dividend (div_dividend),
		.divisor  (ps_eff),
		.done     (div_done),
		.quot     (div_quot)
	);

	pfa_tbl #(.MAX_FRAMES(MAX_FRAMES), .IW(IW), .CW(CW)) u_tbl (
		.clk      (clk),
		.arst_n   (arst_n),
		.raddr    (tbl_raddr),
		.rd_owner (tbl_owner),
		.rd_page  (tbl_page),
		.op       (tbl_op),
		.widx     (tbl_widx),
		.wowner   (pid_q),
		.wpage    (tbl_wpage),
		.busy     (busy_vec),
		.count    (busy_cnt)
	);

	// Table walk: the address goes out in one cycle, the entry is judged in the next.
	assign scan_issue = state_q == pfa_pkg::ST_SCAN && cnt_q != CW'(MAX_FRAMES);
	assign scan_end   = state_q == pfa_pkg::ST_SCAN && cnt_q == CW'(MAX_FRAMES) && !v_s1;
	assign s1_busy    = busy_vec[idx_s1];
	assign s1_own     = s1_busy && tbl_owner == pid_q;
	assign s1_free    = !s1_busy && CW'(idx_s1) < nf_q;

	assign nf_gap  = nf_q > busy_cnt ? nf_q - busy_cnt : '0;
	assign avail   = free_cnt_q < nf_gap ? free_cnt_q : nf_gap;
	assign shrink  = old_q > DW'(nsize_q);
	assign grow_ok = n_q <= DW'(avail) &&
		(21'(top_page_q) + 21'(n_q)) <= 21'(pfa_pkg::PAGE_LIMIT);
	assign rw_ok   = busy_vec[fidx_q] && tbl_owner == pid_q;

	assign is_write   = req_q == pfa_pkg::REQ_WRITE;
	assign byte_issue = state_q == pfa_pkg::ST_BYTES && bk_q != 3'd4;
	assign baddr_sum  = {5'b0, addr_q} + {15'b0, bk_q[1:0]};
	assign baddr_wrap = baddr_sum >= 17'(MEM_BYTES) ? baddr_sum - 17'(MEM_BYTES) : baddr_sum;
	assign baddr      = baddr_wrap[BAW-1:0];

	always_comb begin
		state_d = state_q;
		case (state_q)
			pfa_pkg::ST_IDLE: begin
				if (in_valid) begin
					state_d = req_type > pfa_pkg::REQ_WRITE ? pfa_pkg::ST_FINISH
						: pfa_pkg::ST_NF_DIV;
				end
			end
			pfa_pkg::ST_NF_DIV: state_d = pfa_pkg::ST_NF_WAIT;
			pfa_pkg::ST_NF_WAIT: begin
				if (div_done) begin
					state_d = (req_q == pfa_pkg::REQ_READ || is_write) ? pfa_pkg::ST_RW_DIV
						: pfa_pkg::ST_SCAN;
				end
			end
			pfa_pkg::ST_SCAN: begin
				if (scan_end) begin
					state_d = mode_q == pfa_pkg::SCAN_GATHER ? pfa_pkg::ST_DECIDE
						: pfa_pkg::ST_FINISH;
				end
			end
			pfa_pkg::ST_DECIDE: begin
				case (req_q)
					pfa_pkg::REQ_RESIZE:
						state_d = own_any_q ? pfa_pkg::ST_MUL : pfa_pkg::ST_FINISH;
					pfa_pkg::REQ_RELEASE: state_d = pfa_pkg::ST_SCAN;
					default: state_d = pfa_pkg::ST_FINISH;
				endcase
			end
			pfa_pkg::ST_MUL: state_d = pfa_pkg::ST_SZ_DIV;
			pfa_pkg::ST_SZ_DIV: state_d = pfa_pkg::ST_SZ_WAIT;
			pfa_pkg::ST_SZ_WAIT: begin
				if (div_done) begin
					state_d = pfa_pkg::ST_SZ_DECIDE;
				end
			end
			pfa_pkg::ST_SZ_DECIDE: begin
				state_d = (shrink || (grow_ok && n_q != '0)) ? pfa_pkg::ST_SCAN
					: pfa_pkg::ST_FINISH;
			end
			pfa_pkg::ST_RW_DIV: state_d = pfa_pkg::ST_RW_WAIT;
			pfa_pkg::ST_RW_WAIT: begin
				if (div_done) begin
					state_d = div_quot < DW'(nf_q) ? pfa_pkg::ST_RW_OWN : pfa_pkg::ST_FINISH;
				end
			end
			pfa_pkg::ST_RW_OWN: state_d = pfa_pkg::ST_RW_CHECK;
			pfa_pkg::ST_RW_CHECK: state_d = rw_ok ? pfa_pkg::ST_BYTES : pfa_pkg::ST_FINISH;
			pfa_pkg::ST_BYTES: begin
				if (bk_q == 3'd4 && !kv_s1) begin
					state_d = pfa_pkg::ST_FINISH;
				end
			end
			pfa_pkg::ST_FINISH: begin
				if (!out_valid_q || out_ready) begin
					state_d = pfa_pkg::ST_IDLE;
				end
			end
			default: state_d = pfa_pkg::ST_IDLE;
		endcase
	end

	always_comb begin
		div_start    = 1'b0;
		div_dividend = DW'(addr_q);
		tbl_op       = '0;
		tbl_widx     = idx_s1;
		tbl_wpage    = next_page_q;
		tbl_raddr    = state_q == pfa_pkg::ST_SCAN ? cnt_q[IW-1:0] : fidx_q;
		case (state_q)
			pfa_pkg::ST_NF_DIV: begin
				div_start    = 1'b1;
				div_dividend = DW'(mem_eff);
			end
			pfa_pkg::ST_SZ_DIV: begin
				div_start    = 1'b1;
				div_dividend = shrink ? old_q - DW'(nsize_q) : DW'(nsize_q) - old_q;
			end
			pfa_pkg::ST_RW_DIV: div_start = 1'b1;
			pfa_pkg::ST_SCAN: begin
				if (v_s1 && mode_q == pfa_pkg::SCAN_DROP) begin
					tbl_op.clr = s1_own && tbl_page > thr_q;
				end
				if (v_s1 && mode_q == pfa_pkg::SCAN_ALLOC) begin
					tbl_op.set = s1_free && alloc_left_q != '0;
				end
			end
			pfa_pkg::ST_DECIDE: begin
				if (req_q == pfa_pkg::REQ_START) begin
					tbl_op.set = !own_any_q && free_found_q;
					tbl_widx   = free_idx_q;
					tbl_wpage  = 7'd1;
				end
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= pfa_pkg::ST_IDLE;
			out_valid_q <= 1'b0;
			v_s1        <= 1'b0;
			kv_s1       <= 1'b0;
		end else begin
			state_q <= state_d;
			v_s1    <= scan_issue;
			kv_s1   <= byte_issue && !is_write;
			if (state_q == pfa_pkg::ST_FINISH && (!out_valid_q || out_ready)) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		idx_s1 <= cnt_q[IW-1:0];
		k_s1   <= bk_q[1:0];
		if (scan_issue) begin
			cnt_q <= cnt_q + 1'b1;
		end
		if (byte_issue) begin
			bk_q <= bk_q + 3'd1;
		end
		if (kv_s1) begin
			res_rval_q[{k_s1, 3'b000} +: 8] <= byte_rd_q;
		end
		if (tbl_op.set && state_q == pfa_pkg::ST_SCAN) begin
			alloc_left_q <= alloc_left_q - 1'b1;
			next_page_q  <= next_page_q + 7'd1;
		end
		if (v_s1 && mode_q == pfa_pkg::SCAN_GATHER) begin
			if (s1_own) begin
				own_any_q <= 1'b1;
				if (tbl_page > top_page_q) begin
					top_page_q <= tbl_page;
				end
				if (tbl_page == pnum_q && !found_q) begin
					found_q     <= 1'b1;
					found_idx_q <= idx_s1;
				end
			end
			if (s1_free) begin
				free_cnt_q <= free_cnt_q + 1'b1;
				if (!free_found_q) begin
					free_found_q <= 1'b1;
					free_idx_q   <= idx_s1;
				end
			end
		end
		case (state_q)
			pfa_pkg::ST_IDLE: begin
				if (in_valid) begin
					req_q        <= req_type;
					pid_q        <= pid;
					pnum_q       <= page_number;
					nsize_q      <= new_size;
					addr_q       <= address;
					wval_q       <= write_value;
					res_status_q <= 1'b1;
					res_frame_q  <= '0;
					res_rval_q   <= '0;
				end
			end
			pfa_pkg::ST_NF_WAIT: begin
				nf_q         <= div_quot > DW'(MAX_FRAMES) ? CW'(MAX_FRAMES) : div_quot[CW-1:0];
				mode_q       <= pfa_pkg::SCAN_GATHER;
				cnt_q        <= '0;
				own_any_q    <= 1'b0;
				found_q      <= 1'b0;
				free_found_q <= 1'b0;
				free_cnt_q   <= '0;
				top_page_q   <= '0;
			end
			pfa_pkg::ST_DECIDE: begin
				cnt_q  <= '0;
				mode_q <= pfa_pkg::SCAN_DROP;
				thr_q  <= '0;
				case (req_q)
					pfa_pkg::REQ_START: begin
						if (!own_any_q && free_found_q) begin
							res_status_q <= 1'b0;
							res_frame_q  <= 7'(free_idx_q) + 7'd1;
						end
					end
					pfa_pkg::REQ_RELEASE: res_status_q <= 1'b0;
					pfa_pkg::REQ_LOOKUP: begin
						if (found_q) begin
							res_status_q <= 1'b0;
							res_frame_q  <= 7'(found_idx_q) + 7'd1;
						end
					end
					default: ;
				endcase
			end
			pfa_pkg::ST_MUL: old_q <= DW'(top_page_q) * DW'(ps_eff);
			pfa_pkg::ST_SZ_WAIT: n_q <= div_quot;
			pfa_pkg::ST_SZ_DECIDE: begin
				// Pages of a process run from 1 to its highest, so the shrink drops
				// every page above the new highest one in a single walk.
				cnt_q        <= '0;
				mode_q       <= shrink ? pfa_pkg::SCAN_DROP : pfa_pkg::SCAN_ALLOC;
				thr_q        <= n_q >= DW'(top_page_q) ? 7'd0 : top_page_q - n_q[6:0];
				alloc_left_q <= n_q[CW-1:0];
				next_page_q  <= top_page_q + 7'd1;
				if (shrink || grow_ok) begin
					res_status_q <= 1'b0;
				end
			end
			pfa_pkg::ST_RW_WAIT: fidx_q <= div_quot[IW-1:0];
			pfa_pkg::ST_RW_CHECK: begin
				bk_q <= '0;
				if (rw_ok) begin
					res_status_q <= 1'b0;
					res_frame_q  <= 7'(fidx_q) + 7'd1;
				end
			end
			pfa_pkg::ST_FINISH: begin
				if (!out_valid_q || out_ready) begin
					out_status_q <= res_status_q;
					out_frame_q  <= res_frame_q;
					out_rval_q   <= res_rval_q;
				end
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk) begin
		if (byte_issue && is_write) begin
			byte_mem[baddr] <= wval_q[{bk_q[1:0], 3'b000} +: 8];
		end
		byte_rd_q <= byte_mem[baddr];
	end

	assign out_valid    = out_valid_q;
	assign status       = out_status_q;
	assign frame_number = out_frame_q;
	assign read_value   = out_rval_q;

endmodule

[sim/tb_paged_frame_allocator.sv]
`timescale 1ns / 1ps

module tb_paged_frame_allocator;

	localparam int NFRAMES = 64;
	localparam int NBYTES = 4096;
	localparam int STALL_LIMIT = 20000;
	localparam int DRAIN_CYCLES = 400;

	typedef struct {
		logic        status;
		logic [6:0]  frame;
		logic [31:0] rdata;
	} result_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        in_valid = 1'b0;
	logic        in_ready;
	logic [2:0]  req_type = '0;
	logic [15:0] pid = '0;
	logic [6:0]  page_number = '0;
	logic [12:0] new_size = '0;
	logic [11:0] address = '0;
	logic [31:0] write_value = '0;
	logic        out_valid;
	logic        out_ready = 1'b0;
	logic        status;
	logic [6:0]  frame_number;
	logic [31:0] read_value;
	logic        cfg_valid = 1'b0;
	logic        cfg_ready;
	logic        cfg_index = 1'b0;
	logic [12:0] cfg_data = '0;

	// Allocator state as the checker believes it to be.
	logic        frm_busy [NFRAMES];
	logic [15:0] frm_owner [NFRAMES];
	logic [6:0]  frm_page [NFRAMES];
	int unsigned busy_frames;
	logic [7:0]  mem_bytes [NBYTES];
	logic        mem_known [NBYTES];
	logic [12:0] page_size_reg = pfa_pkg::PAGE_SIZE_RESET;
	logic [12:0] mem_size_reg = pfa_pkg::MEM_SIZE_RESET;

	result_t     pending_results [$];
	int          fail_count = 0;
	int          send_gap_pct = 0;
	int          stall_pct = 0;
	int          idle_count = 0;

	paged_frame_allocator uut (.*);

	always #5 clk = ~clk;

	function automatic int unsigned eff_page();
		return (page_size_reg == 0) ? 1 : page_size_reg;
	endfunction

	function automatic int unsigned usable_frames();
		int unsigned ms;
		int unsigned nf;
		ms = (mem_size_reg > NBYTES) ? NBYTES : mem_size_reg;
		nf = ms / eff_page();
		return (nf > NFRAMES) ? NFRAMES : nf;
	endfunction

	function automatic int highest_frame(logic [15:0] p);
		int best;
		best = -1;
		for (int i = 0; i < NFRAMES; i++)
			if (frm_busy[i] && frm_owner[i] == p && (best < 0 || frm_page[i] > frm_page[best]))
				best = i;
		return best;
	endfunction

	function automatic int unsigned claim_frame(logic [15:0] p, int unsigned pg);
		for (int i = 0; i < usable_frames(); i++)
			if (!frm_busy[i]) begin
				frm_busy[i] = 1'b1;
				frm_owner[i] = p;
				frm_page[i] = pg[6:0];
				busy_frames++;
				return i + 1;
			end
		return 0;
	endfunction

	function automatic void free_frame(int i);
		frm_busy[i] = 1'b0;
		frm_owner[i] = '0;
		frm_page[i] = '0;
		if (busy_frames > 0)
			busy_frames--;
	endfunction

	// Frame a read or write of this address would touch, or 0 when refused.
	function automatic int unsigned access_frame(logic [15:0] p, logic [11:0] a);
		int unsigned f;
		f = a / eff_page() + 1;
		if (f <= usable_frames() && frm_busy[f-1] && frm_owner[f-1] == p)
			return f;
		return 0;
	endfunction

	function automatic result_t allocate_result(logic [2:0] rq, logic [15:0] p,
			logic [6:0] pg, logic [12:0] nsize, logic [11:0] a, logic [31:0] wval);
		result_t r;
		int top;
		int unsigned ps, last, old, n, nf, avail, freeable, f, b;
		r.status = 1'b1;
		r.frame = '0;
		r.rdata = '0;
		ps = eff_page();
		case (rq)
			pfa_pkg::REQ_START: begin
				if (highest_frame(p) < 0) begin
					f = claim_frame(p, 1);
					r.frame = f[6:0];
					r.status = (f == 0);
				end
			end
			pfa_pkg::REQ_RESIZE: begin
				top = highest_frame(p);
				if (top >= 0) begin
					last = frm_page[top];
					old = last * ps;
					if (old > nsize) begin
						n = (old - nsize) / ps;
						for (int k = 0; k < n; k++) begin
							top = highest_frame(p);
							if (top < 0)
								break;
							free_frame(top);
						end
						r.status = 1'b0;
					end else begin
						n = (nsize - old) / ps;
						nf = usable_frames();
						avail = (nf > busy_frames) ? nf - busy_frames : 0;
						freeable = 0;
						for (int i = 0; i < nf; i++)
							if (!frm_busy[i])
								freeable++;
						if (freeable < avail)
							avail = freeable;
						if (n <= avail && last + n <= pfa_pkg::PAGE_LIMIT) begin
							for (int k = 0; k < n; k++)
								void'(claim_frame(p, last + 1 + k));
							r.status = 1'b0;
						end
					end
				end
			end
			pfa_pkg::REQ_RELEASE: begin
				for (int i = 0; i < NFRAMES; i++)
					if (frm_busy[i] && frm_owner[i] == p)
						free_frame(i);
				r.status = 1'b0;
			end
			pfa_pkg::REQ_LOOKUP: begin
				for (int i = 0; i < NFRAMES; i++)
					if (frm_busy[i] && frm_owner[i] == p && frm_page[i] == pg) begin
						r.frame = 7'(i + 1);
						r.status = 1'b0;
						break;
					end
			end
			pfa_pkg::REQ_READ, pfa_pkg::REQ_WRITE: begin
				f = access_frame(p, a);
				if (f != 0) begin
					r.status = 1'b0;
					r.frame = f[6:0];
					for (int k = 0; k < 4; k++) begin
						b = (a + k) % NBYTES;
						if (rq == pfa_pkg::REQ_READ)
							r.rdata[8*k +: 8] = mem_bytes[b];
						else begin
							mem_bytes[b] = wval[8*k +: 8];
							mem_known[b] = 1'b1;
						end
					end
				end
			end
			default: ;
		endcase
		return r;
	endfunction

	task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
		$display("%0t: mismatch on %s: got 0x%0h, expected 0x%0h", $realtime, what, got, want);
		fail_count++;
	endtask

	// Sends one request; the expected result is worked out at acceptance.
	task automatic send_request(logic [2:0] rq, logic [15:0] p, logic [6:0] pg,
			logic [12:0] nsize, logic [11:0] a, logic [31:0] wval);
		if ($urandom_range(0, 99) < send_gap_pct) begin
			in_valid <= 1'b0;
			repeat ($urandom_range(1, 4)) @(posedge clk);
		end
		in_valid <= 1'b1;
		req_type <= rq;
		pid <= p;
		page_number <= pg;
		new_size <= nsize;
		address <= a;
		write_value <= wval;
		@(posedge clk);
		while (!in_ready)
			@(posedge clk);
		pending_results.push_back(allocate_result(rq, p, pg, nsize, a, wval));
	endtask

	task automatic wait_drained();
		in_valid <= 1'b0;
		while (pending_results.size() != 0)
			@(posedge clk);
	endtask

	task automatic write_register(logic idx, logic [12:0] data);
		wait_drained();
		repeat (DRAIN_CYCLES) @(posedge clk);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= data;
		@(posedge clk);
		while (!cfg_ready)
			@(posedge clk);
		cfg_valid <= 1'b0;
		if (idx == pfa_pkg::CFG_PAGE_SIZE)
			page_size_reg = data;
		else
			mem_size_reg = data;
	endtask

	// One random request, mostly well formed for a small pool of processes.
	task automatic random_request();
		logic [2:0]  rq;
		logic [15:0] p;
		logic [6:0]  pg;
		logic [12:0] nsize;
		logic [11:0] a;
		int          sel, top, f, owned [$];
		int unsigned ps, old;
		ps = eff_page();
		sel = $urandom_range(0, 99);
		p = (sel < 70) ? 16'($urandom_range(1, 6)) : (sel < 80) ? 16'd0 :
			(sel < 90) ? 16'hFFFF : 16'($urandom);
		sel = $urandom_range(0, 99);
		rq = (sel < 15) ? pfa_pkg::REQ_START : (sel < 35) ? pfa_pkg::REQ_RESIZE :
			(sel < 42) ? pfa_pkg::REQ_RELEASE : (sel < 58) ? pfa_pkg::REQ_LOOKUP :
			(sel < 74) ? pfa_pkg::REQ_READ : (sel < 95) ? pfa_pkg::REQ_WRITE :
			3'($urandom_range(6, 7));
		pg = 7'($urandom);
		nsize = 13'($urandom);
		a = 12'($urandom);
		top = highest_frame(p);
		if (rq == pfa_pkg::REQ_LOOKUP && top >= 0 && $urandom_range(0, 3) != 0)
			pg = 7'(frm_page[top] + 1 - $urandom_range(0, frm_page[top]));
		if (rq == pfa_pkg::REQ_RESIZE && $urandom_range(0, 4) != 0) begin
			old = (top >= 0) ? frm_page[top] * ps : 0;
			sel = int'(old) + ($urandom_range(0, 6) - 3) * int'(ps) +
				int'($urandom_range(0, ps - 1));
			nsize = (sel < 0) ? 13'd0 : (sel > 8191) ? 13'h1FFF : 13'(sel);
		end
		if ((rq == pfa_pkg::REQ_READ || rq == pfa_pkg::REQ_WRITE) &&
				$urandom_range(0, 4) != 0) begin
			for (int i = 0; i < NFRAMES; i++)
				if (frm_busy[i] && frm_owner[i] == p)
					owned.push_back(i);
			if (owned.size() != 0) begin
				f = owned[$urandom_range(0, owned.size() - 1)];
				old = f * ps + $urandom_range(0, ps - 1);
				a = (old > 4095) ? 12'hFFF : 12'(old);
			end
		end
		// Never read memory that has not been written: turn it into a write.
		if (rq == pfa_pkg::REQ_READ && access_frame(p, a) != 0)
			for (int k = 0; k < 4; k++)
				if (!mem_known[(a + k) % NBYTES])
					rq = pfa_pkg::REQ_WRITE;
		send_request(rq, p, pg, nsize, a, $urandom);
	endtask

	task automatic random_burst(int count);
		for (int i = 0; i < count; i++)
			random_request();
	endtask

	task automatic release_pool();
		send_request(pfa_pkg::REQ_RELEASE, 16'd0, '0, '0, '0, '0);
		send_request(pfa_pkg::REQ_RELEASE, 16'hFFFF, '0, '0, '0, '0);
		for (int i = 1; i <= 6; i++)
			send_request(pfa_pkg::REQ_RELEASE, 16'(i), '0, '0, '0, '0);
	endtask

	task automatic test_directed();
		send_request(pfa_pkg::REQ_START, 16'd1, '0, '0, '0, '0);
		send_request(pfa_pkg::REQ_START, 16'd1, '0, '0, '0, '0);
		send_request(pfa_pkg::REQ_LOOKUP, 16'd1, 7'd1, '0, '0, '0);
		send_request(pfa_pkg::REQ_WRITE, 16'd1, '0, '0, 12'd0, 32'hFFFF_FFFF);
		send_request(pfa_pkg::REQ_READ, 16'd1, '0, '0, 12'd0, '0);
		send_request(pfa_pkg::REQ_WRITE, 16'd2, '0, '0, 12'd4, 32'h1234_5678);
		send_request(pfa_pkg::REQ_RESIZE, 16'd1, '0, 13'd256, '0, '0);
		send_request(pfa_pkg::REQ_LOOKUP, 16'd1, 7'd4, '0, '0, '0);
		send_request(pfa_pkg::REQ_LOOKUP, 16'd1, 7'd5, '0, '0, '0);
		send_request(pfa_pkg::REQ_RESIZE, 16'd1, '0, 13'd0, '0, '0);
		send_request(pfa_pkg::REQ_RESIZE, 16'd1, '0, 13'd64, '0, '0);
		send_request(pfa_pkg::REQ_RELEASE, 16'd9, '0, '0, '0, '0);
		send_request(pfa_pkg::REQ_START, 16'hFFFF, 7'h7F, 13'h1FFF, 12'hFFF, 32'h0);
		send_request(pfa_pkg::REQ_RESIZE, 16'hFFFF, '0, 13'd4096, '0, '0);
		send_request(pfa_pkg::REQ_START, 16'd2, '0, '0, '0, '0);
		send_request(pfa_pkg::REQ_RESIZE, 16'hFFFF, '0, 13'h1FFF, '0, '0);
		// The word at the top of memory wraps round to byte zero.
		send_request(pfa_pkg::REQ_WRITE, 16'hFFFF, '0, '0, 12'hFFE, 32'hA5C3_0F96);
		send_request(pfa_pkg::REQ_READ, 16'hFFFF, '0, '0, 12'hFFE, '0);
		send_request(pfa_pkg::REQ_LOOKUP, 16'hFFFF, 7'd64, '0, '0, '0);
		wait_drained();
		send_request(3'd6, 16'hFFFF, 7'h7F, 13'h1FFF, 12'hFFF, 32'hFFFF_FFFF);
		send_request(3'd7, 16'd0, '0, '0, '0, '0);
		send_request(pfa_pkg::REQ_RELEASE, 16'hFFFF, '0, '0, '0, '0);
	endtask

	task automatic test_register_settings();
		logic [12:0] page_list [8] = '{13'd0, 13'd1, 13'd4096, 13'h1FFF, 13'd100,
			13'd32, 13'd1, 13'd64};
		logic [12:0] mem_list [8] = '{13'd64, 13'h1FFF, 13'd4096, 13'd4096, 13'd3000,
			13'd0, 13'd1, 13'd4096};
		for (int i = 0; i < 8; i++) begin
			write_register(pfa_pkg::CFG_PAGE_SIZE, page_list[i]);
			write_register(pfa_pkg::CFG_MEM_SIZE, mem_list[i]);
			release_pool();
			random_burst(50);
		end
	endtask

	task automatic test_random_traffic(int gap_pct, int stall, int count);
		send_gap_pct = gap_pct;
		stall_pct = stall;
		random_burst(count);
	endtask

	always @(posedge clk)
		out_ready <= ($urandom_range(0, 99) >= stall_pct);

	always @(posedge clk) begin
		result_t want;
		if (arst_n && out_valid && out_ready) begin
			if (pending_results.size() == 0) begin
				$display("%0t: result item with no request outstanding", $realtime);
				fail_count++;
			end else begin
				want = pending_results.pop_front();
				if (status !== want.status)
					report_mismatch("status", 32'(status), 32'(want.status));
				if (frame_number !== want.frame)
					report_mismatch("frame_number", 32'(frame_number), 32'(want.frame));
				if (read_value !== want.rdata)
					report_mismatch("read_value", read_value, want.rdata);
			end
		end
	end

	always @(posedge clk) begin
		if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready))
			idle_count <= 0;
		else
			idle_count <= idle_count + 1;
		if (idle_count >= STALL_LIMIT) begin
			$display("Regression FAIL");
			$finish;
		end
	end

	initial begin
		for (int i = 0; i < NFRAMES; i++) begin
			frm_busy[i] = 1'b0;
			frm_owner[i] = '0;
			frm_page[i] = '0;
		end
		for (int i = 0; i < NBYTES; i++) begin
			mem_bytes[i] = '0;
			mem_known[i] = 1'b0;
		end
		busy_frames = 0;
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_directed();
		test_register_settings();
		test_random_traffic(10, 64, 350);
		test_random_traffic(64, 10, 350);
		test_random_traffic(0, 0, 350);
		wait_drained();
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (fail_count == 0)
			$display("Regression PASS");
		else
			$display("Regression FAIL");
		$finish;
	end

endmodule
